### rtl/core/esdp_pkg.sv
// Shared types, constants and helper functions of the esds descriptor parser.
package esdp_pkg;

   localparam int MAX_LENGTH_BYTES = 4;   // length bytes read before a length is cut off
   localparam int LEN_W            = 28;  // descriptor length width
   localparam int CNT_W            = 3;   // byte counter width

   localparam logic [7:0] TAG_ES  = 8'h03;
   localparam logic [7:0] TAG_DEC = 8'h04;
   localparam logic [7:0] TAG_DSI = 8'h05;

   localparam logic [LEN_W-1:0] ES_MIN_LEN  = LEN_W'(20);
   localparam logic [LEN_W-1:0] DEC_MIN_LEN = LEN_W'(15);

   localparam logic [CNT_W-1:0] HDR_BYTES   = CNT_W'(4);
   localparam logic [CNT_W-1:0] SKIP_BYTES  = CNT_W'(2);
   localparam logic [CNT_W-1:0] ESID_BYTES  = CNT_W'(2);
   localparam logic [CNT_W-1:0] BUF_BYTES   = CNT_W'(3);
   localparam logic [CNT_W-1:0] RATE_BYTES  = CNT_W'(4);
   localparam logic [CNT_W-1:0] LEN_LIMIT   = CNT_W'(MAX_LENGTH_BYTES);

   localparam int RSP_DATA_W = 200;

   typedef enum logic [4:0] {
      PH_IDLE, PH_HDR, PH_TAG1, PH_SKIP, PH_ES_LEN, PH_ESID, PH_PRIO,
      PH_TAG2, PH_DEC_LEN, PH_OBJ, PH_STYPE, PH_BUF, PH_MAXR, PH_AVGR,
      PH_TAG3, PH_CFG_LEN, PH_CFG
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY      = 3'd0,
      ST_DONE      = 3'd1,
      ST_SHORT_ES  = 3'd2,
      ST_NO_DEC    = 3'd3,
      ST_SHORT_DEC = 3'd4,
      ST_NO_DSI    = 3'd5,
      ST_IGNORED   = 3'd6
   } status_type;

   typedef struct packed {
      phase_type         phase;
      logic [CNT_W-1:0]  field_cnt;
      logic [LEN_W-1:0]  len_acc;
      logic [CNT_W-1:0]  len_cnt;
      logic [LEN_W-1:0]  cfg_rem;
      logic              cfg_len_known;
      logic [31:0]       box_word;
      logic [15:0]       stream_id;
      logic [7:0]        priority_val;
      logic [7:0]        object_type;
      logic [7:0]        stream_type;
      logic [23:0]       buffer_size;
      logic [31:0]       max_rate;
      logic [31:0]       avg_rate;
   } state_type;

   typedef struct packed {
      status_type        status;
      logic [7:0]        config_byte;
      logic              config_valid;
      logic [31:0]       full_box_word;
      logic [15:0]       es_id;
      logic [7:0]        es_priority;
      logic [7:0]        object_type;
      logic [7:0]        stream_type;
      logic [23:0]       buffer_size;
      logic [31:0]       max_bitrate;
      logic [31:0]       avg_bitrate;
      logic [LEN_W-1:0]  config_length;
   } result_type;

   typedef struct packed {
      logic              done;
      logic [CNT_W-1:0]  cnt;
   } field_type;

   typedef struct packed {
      logic              done;
      logic [LEN_W-1:0]  acc;
      logic [CNT_W-1:0]  cnt;
   } length_type;

   // Count one byte of a multi-byte field; wrap to zero once all are in.
   function automatic field_type field_step(input logic [CNT_W-1:0] cnt,
                                            input logic [CNT_W-1:0] total);
      field_type        r;
      logic [CNT_W-1:0] inc;
      inc = cnt + CNT_W'(1);
      r.done = (inc >= total);
      r.cnt  = r.done ? '0 : inc;
      return r;
   endfunction

   // Shift in one 7-bit length group; done on a clear continuation bit or at the limit.
   function automatic length_type length_step(input logic [LEN_W-1:0] acc,
                                              input logic [CNT_W-1:0] cnt,
                                              input logic [7:0]       data_byte);
      length_type r;
      r.acc  = {acc[LEN_W-8:0], data_byte[6:0]};
      r.cnt  = cnt + CNT_W'(1);
      r.done = !data_byte[7] || (r.cnt >= LEN_LIMIT);
      return r;
   endfunction

endpackage

### rtl/core/esdp_step.sv
// Per-byte parser step: next phase, field updates and the result word.
module esdp_step (
   input  esdp_pkg::state_type  cur_state,
   input  logic [7:0]           data_byte,
   input  logic                 box_start,
   output esdp_pkg::state_type  next_state,
   output esdp_pkg::result_type result
);
   import esdp_pkg::*;

   state_type  base;
   state_type  upd;
   phase_type  phase_in;
   status_type status;
   logic [7:0] cbyte;
   logic       cvalid;
   field_type  fld;
   length_type len;
   logic [LEN_W-1:0] rem_dec;

   // restart: clear everything, treat this byte as the version byte
   always_comb begin
      base = cur_state;
      if (box_start) begin
         base       = '0;
         base.phase = PH_HDR;
      end
   end

   always_comb begin
      fld     = field_step(base.field_cnt, HDR_BYTES);
      len     = length_step(base.len_acc, base.len_cnt, data_byte);
      rem_dec = base.cfg_rem - LEN_W'(1);
      unique case (base.phase)
         PH_HDR:   fld = field_step(base.field_cnt, HDR_BYTES);
         PH_SKIP:  fld = field_step(base.field_cnt, SKIP_BYTES);
         PH_ESID:  fld = field_step(base.field_cnt, ESID_BYTES);
         PH_BUF:   fld = field_step(base.field_cnt, BUF_BYTES);
         PH_MAXR, PH_AVGR: fld = field_step(base.field_cnt, RATE_BYTES);
         default:  fld = field_step(base.field_cnt, HDR_BYTES);
      endcase
   end

   // next phase
   always_comb begin
      phase_in = base.phase;
      unique case (base.phase)
         PH_HDR:     if (fld.done) phase_in = PH_TAG1;
         PH_TAG1:    phase_in = (data_byte == TAG_ES) ? PH_ES_LEN : PH_SKIP;
         PH_SKIP:    if (fld.done) phase_in = PH_TAG2;
         PH_ES_LEN:  if (len.done) phase_in = (len.acc < ES_MIN_LEN) ? PH_IDLE : PH_ESID;
         PH_ESID:    if (fld.done) phase_in = PH_PRIO;
         PH_PRIO:    phase_in = PH_TAG2;
         PH_TAG2:    phase_in = (data_byte == TAG_DEC) ? PH_DEC_LEN : PH_IDLE;
         PH_DEC_LEN: if (len.done) phase_in = (len.acc < DEC_MIN_LEN) ? PH_IDLE : PH_OBJ;
         PH_OBJ:     phase_in = PH_STYPE;
         PH_STYPE:   phase_in = PH_BUF;
         PH_BUF:     if (fld.done) phase_in = PH_MAXR;
         PH_MAXR:    if (fld.done) phase_in = PH_AVGR;
         PH_AVGR:    if (fld.done) phase_in = PH_TAG3;
         PH_TAG3:    phase_in = (data_byte == TAG_DSI) ? PH_CFG_LEN : PH_IDLE;
         PH_CFG_LEN: if (len.done) phase_in = (len.acc == '0) ? PH_IDLE : PH_CFG;
         PH_CFG:     if (rem_dec == '0) phase_in = PH_IDLE;
         default:    phase_in = PH_IDLE;
      endcase
   end

   // field updates and status
   always_comb begin
      upd    = base;
      status = ST_BUSY;
      cbyte  = '0;
      cvalid = 1'b0;
      unique case (base.phase)
         PH_HDR: begin
            upd.box_word  = {base.box_word[23:0], data_byte};
            upd.field_cnt = fld.cnt;
         end
         PH_TAG1: begin
            upd.field_cnt = '0;
            if (data_byte == TAG_ES) begin
               upd.len_acc = '0;
               upd.len_cnt = '0;
            end
         end
         PH_SKIP: upd.field_cnt = fld.cnt;
         PH_ES_LEN: begin
            upd.len_acc = len.acc;
            upd.len_cnt = len.cnt;
            if (len.done) begin
               if (len.acc < ES_MIN_LEN) status = ST_SHORT_ES;
               else upd.field_cnt = '0;
            end
         end
         PH_ESID: begin
            upd.stream_id = {base.stream_id[7:0], data_byte};
            upd.field_cnt = fld.cnt;
         end
         PH_PRIO: upd.priority_val = data_byte;
         PH_TAG2: begin
            if (data_byte != TAG_DEC) begin
               status = ST_NO_DEC;
            end else begin
               upd.len_acc = '0;
               upd.len_cnt = '0;
            end
         end
         PH_DEC_LEN: begin
            upd.len_acc = len.acc;
            upd.len_cnt = len.cnt;
            if (len.done && (len.acc < DEC_MIN_LEN)) status = ST_SHORT_DEC;
         end
         PH_OBJ: upd.object_type = data_byte;
         PH_STYPE: begin
            upd.stream_type = data_byte;
            upd.field_cnt   = '0;
         end
         PH_BUF: begin
            upd.buffer_size = {base.buffer_size[15:0], data_byte};
            upd.field_cnt   = fld.cnt;
         end
         PH_MAXR: begin
            upd.max_rate  = {base.max_rate[23:0], data_byte};
            upd.field_cnt = fld.cnt;
         end
         PH_AVGR: begin
            upd.avg_rate  = {base.avg_rate[23:0], data_byte};
            upd.field_cnt = fld.cnt;
         end
         PH_TAG3: begin
            if (data_byte != TAG_DSI) begin
               status = ST_NO_DSI;
            end else begin
               upd.len_acc = '0;
               upd.len_cnt = '0;
            end
         end
         PH_CFG_LEN: begin
            upd.len_acc = len.acc;
            upd.len_cnt = len.cnt;
            if (len.done) begin
               upd.cfg_len_known = 1'b1;
               upd.cfg_rem       = len.acc;
               if (len.acc == '0) status = ST_DONE;
            end
         end
         PH_CFG: begin
            cbyte       = data_byte;
            cvalid      = 1'b1;
            upd.cfg_rem = rem_dec;
            if (rem_dec == '0) status = ST_DONE;
         end
         default: status = ST_IGNORED;
      endcase
   end

   always_comb begin
      next_state       = upd;
      next_state.phase = phase_in;
   end

   always_comb begin
      result.status        = status;
      result.config_byte   = cbyte;
      result.config_valid  = cvalid;
      result.full_box_word = upd.box_word;
      result.es_id         = upd.stream_id;
      result.es_priority   = upd.priority_val;
      result.object_type   = upd.object_type;
      result.stream_type   = upd.stream_type;
      result.buffer_size   = upd.buffer_size;
      result.max_bitrate   = upd.max_rate;
      result.avg_bitrate   = upd.avg_rate;
      result.config_length = upd.cfg_len_known ? upd.len_acc : '0;
   end

endmodule

### rtl/core/es_descriptor_parser_unit.sv
// Top level of the esds descriptor parser: input register, parser state, result register.
//
//  channel  dir  handshake               payload
//  req      in   req_tvalid/req_tready   req_tdata = payload byte, req_tuser = box start
//  rsp      out  rsp_tvalid/rsp_tready   rsp_tdata = status and parsed fields,
//                                        rsp_tuser = specific info byte valid
//
// Every accepted byte yields exactly one result word; one byte per cycle unless rsp stalls.
// A byte passes the input register, then the parser step into the result register.
// The step is a small phase machine plus shift-in of the current field byte.
// reset (synchronous) clears the parser to idle with all fields zero.
// A stalled rsp holds the result register; the input register then holds one more
// byte, and req_tready drops only when both are full.
module es_descriptor_parser_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] data_byte
   input  logic                               req_tuser,   // [0] box_start
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [2:0] status, [10:3] config_byte, [42:11] full_box_word, [58:43] es_id,
   // [66:59] es_priority, [74:67] object_type, [82:75] stream_type,
   // [106:83] buffer_size, [138:107] max_bitrate, [170:139] avg_bitrate,
   // [198:171] config_length, [199] zero
   output logic [esdp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser    // [0] config_valid
);
   import esdp_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;
   logic       in_start_ff, in_start_in;

   // parser state
   state_type  state_ff, state_in;
   state_type  step_state;
   result_type step_result;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;
   logic                  rsp_user_ff,  rsp_user_in;

   logic advance;
   logic fire;
   logic req_take;

   // result slot is free, or drains this cycle
   assign advance  = !rsp_valid_ff || rsp_tready;
   assign fire     = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take = req_tvalid && req_tready;

   esdp_step u_step (
      .cur_state  (state_ff),
      .data_byte  (in_byte_ff),
      .box_start  (in_start_ff),
      .next_state (step_state),
      .result     (step_result)
   );

   always_comb begin
      // hold the staged byte until the step consumes it
      in_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      in_byte_in  = req_take ? req_tdata : in_byte_ff;
      in_start_in = req_take ? req_tuser : in_start_ff;
   end

   always_comb begin
      // advance parser state only when a byte is processed
      state_in = fire ? step_state : state_ff;
   end

   always_comb begin
      rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (fire) begin
         rsp_data_in = {1'b0,
                        step_result.config_length,
                        step_result.avg_bitrate,
                        step_result.max_bitrate,
                        step_result.buffer_size,
                        step_result.stream_type,
                        step_result.object_type,
                        step_result.es_priority,
                        step_result.es_id,
                        step_result.full_box_word,
                        step_result.config_byte,
                        step_result.status};
         rsp_user_in = step_result.config_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;   // all zero is the idle phase with cleared fields
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_start_ff <= in_start_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### bench/es_descriptor_parser_unit_test.sv
// Self-checking stream testbench of the esds descriptor parser, with its own byte-level predictor.
module es_descriptor_parser_unit_test;
   import esdp_pkg::*;

   localparam int ITEM_COUNT     = 120;   // parsed (not ignored) bytes in the random part
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving on either side
   localparam int REPORT_LIMIT   = 40;    // mismatches printed before going quiet
   localparam int MAX_DSI_SENT   = 48;    // specific info bytes sent per box at most
   localparam int TAIL_CYCLES    = 8;

   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_mode_type;

   // Shape of one esds payload as the generator lays it out.
   typedef struct {
      bit            has_es;
      logic [7:0]    other_tag;
      int unsigned   es_len;
      int            es_nbytes;
      bit            es_long;
      logic [7:0]    dec_tag;
      int unsigned   dec_len;
      int            dec_nbytes;
      bit            dec_long;
      logic [7:0]    dsi_tag;
      int unsigned   cfg_len;
      int            cfg_nbytes;
      bit            cfg_long;
      fill_mode_type fill;
   } box_spec_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;   // [7:0] data_byte
   logic                  req_tuser  = 1'b0;    // [0] box_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [2:0] status, [10:3] config_byte, [42:11] full_box_word, [58:43] es_id,
   // [66:59] es_priority, [74:67] object_type, [82:75] stream_type,
   // [106:83] buffer_size, [138:107] max_bitrate, [170:139] avg_bitrate,
   // [198:171] config_length
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;            // [0] config_valid

   es_descriptor_parser_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Predicted parser state.
   phase_type        ps_phase     = PH_IDLE;
   logic [CNT_W-1:0] ps_field_cnt = '0;
   logic [LEN_W-1:0] ps_len       = '0;
   logic [CNT_W-1:0] ps_len_cnt   = '0;
   logic [LEN_W-1:0] ps_cfg_left  = '0;
   logic             ps_cfg_known = 1'b0;
   logic [31:0]      ps_box_word  = '0;
   logic [15:0]      ps_es_id     = '0;
   logic [7:0]       ps_priority  = '0;
   logic [7:0]       ps_obj_type  = '0;
   logic [7:0]       ps_strm_type = '0;
   logic [23:0]      ps_buf_size  = '0;
   logic [31:0]      ps_max_rate  = '0;
   logic [31:0]      ps_avg_rate  = '0;

   result_type  expected_words[$];   // one predicted result word per accepted byte
   result_type  head;
   logic [7:0]  frame[$];            // bytes of the box being sent

   int send_idle_pct  = 29;
   int recv_idle_pct  = 74;
   int parsed_items   = 0;
   int ignored_items  = 0;
   int boxes_sent     = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int status_seen[8];

   function automatic void clear_parser();
      ps_phase     = PH_IDLE;
      ps_field_cnt = '0;
      ps_len       = '0;
      ps_len_cnt   = '0;
      ps_cfg_left  = '0;
      ps_cfg_known = 1'b0;
      ps_box_word  = '0;
      ps_es_id     = '0;
      ps_priority  = '0;
      ps_obj_type  = '0;
      ps_strm_type = '0;
      ps_buf_size  = '0;
      ps_max_rate  = '0;
      ps_avg_rate  = '0;
   endfunction

   function automatic void restart_length();
      ps_len     = '0;
      ps_len_cnt = '0;
   endfunction

   // Advance the field byte counter; true once total bytes are in.
   function automatic bit count_field(input logic [CNT_W-1:0] total);
      ps_field_cnt = ps_field_cnt + CNT_W'(1);
      if (ps_field_cnt >= total) begin
         ps_field_cnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Shift in one 7-bit length group; true when the length is complete.
   function automatic bit shift_length(input logic [7:0] b);
      ps_len     = {ps_len[LEN_W-8:0], b[6:0]};
      ps_len_cnt = ps_len_cnt + CNT_W'(1);
      return !b[7] || (ps_len_cnt >= LEN_LIMIT);
   endfunction

   // Step the predicted parser by one byte and queue the result word it yields.
   task automatic predict_parse(input logic [7:0] b, input logic first, output status_type st);
      result_type r;
      r  = '0;
      st = ST_BUSY;
      if (first) begin
         clear_parser();
         ps_phase = PH_HDR;
      end
      case (ps_phase)
         PH_HDR: begin
            ps_box_word = {ps_box_word[23:0], b};
            if (count_field(HDR_BYTES)) ps_phase = PH_TAG1;
         end
         PH_TAG1: begin
            ps_field_cnt = '0;
            if (b == TAG_ES) begin
               restart_length();
               ps_phase = PH_ES_LEN;
            end else begin
               ps_phase = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (count_field(SKIP_BYTES)) ps_phase = PH_TAG2;
         end
         PH_ES_LEN: begin
            if (shift_length(b)) begin
               if (ps_len < ES_MIN_LEN) begin
                  st       = ST_SHORT_ES;
                  ps_phase = PH_IDLE;
               end else begin
                  ps_field_cnt = '0;
                  ps_phase     = PH_ESID;
               end
            end
         end
         PH_ESID: begin
            ps_es_id = {ps_es_id[7:0], b};
            if (count_field(ESID_BYTES)) ps_phase = PH_PRIO;
         end
         PH_PRIO: begin
            ps_priority = b;
            ps_phase    = PH_TAG2;
         end
         PH_TAG2: begin
            if (b != TAG_DEC) begin
               st       = ST_NO_DEC;
               ps_phase = PH_IDLE;
            end else begin
               restart_length();
               ps_phase = PH_DEC_LEN;
            end
         end
         PH_DEC_LEN: begin
            if (shift_length(b)) begin
               if (ps_len < DEC_MIN_LEN) begin
                  st       = ST_SHORT_DEC;
                  ps_phase = PH_IDLE;
               end else begin
                  ps_phase = PH_OBJ;
               end
            end
         end
         PH_OBJ: begin
            ps_obj_type = b;
            ps_phase    = PH_STYPE;
         end
         PH_STYPE: begin
            ps_strm_type = b;
            ps_field_cnt = '0;
            ps_phase     = PH_BUF;
         end
         PH_BUF: begin
            ps_buf_size = {ps_buf_size[15:0], b};
            if (count_field(BUF_BYTES)) ps_phase = PH_MAXR;
         end
         PH_MAXR: begin
            ps_max_rate = {ps_max_rate[23:0], b};
            if (count_field(RATE_BYTES)) ps_phase = PH_AVGR;
         end
         PH_AVGR: begin
            ps_avg_rate = {ps_avg_rate[23:0], b};
            if (count_field(RATE_BYTES)) ps_phase = PH_TAG3;
         end
         PH_TAG3: begin
            if (b != TAG_DSI) begin
               st       = ST_NO_DSI;
               ps_phase = PH_IDLE;
            end else begin
               restart_length();
               ps_phase = PH_CFG_LEN;
            end
         end
         PH_CFG_LEN: begin
            if (shift_length(b)) begin
               ps_cfg_known = 1'b1;
               ps_cfg_left  = ps_len;
               // an empty specific info ends the box on its last length byte
               if (ps_cfg_left == '0) begin
                  st       = ST_DONE;
                  ps_phase = PH_IDLE;
               end else begin
                  ps_phase = PH_CFG;
               end
            end
         end
         PH_CFG: begin
            r.config_byte  = b;
            r.config_valid = 1'b1;
            ps_cfg_left    = ps_cfg_left - LEN_W'(1);
            if (ps_cfg_left == '0) begin
               st       = ST_DONE;
               ps_phase = PH_IDLE;
            end
         end
         default: begin
            // idle: drop the byte and hold every field
            ps_phase = PH_IDLE;
            st       = ST_IGNORED;
         end
      endcase
      r.status        = st;
      r.full_box_word = ps_box_word;
      r.es_id         = ps_es_id;
      r.es_priority   = ps_priority;
      r.object_type   = ps_obj_type;
      r.stream_type   = ps_strm_type;
      r.buffer_size   = ps_buf_size;
      r.max_bitrate   = ps_max_rate;
      r.avg_bitrate   = ps_avg_rate;
      r.config_length = ps_cfg_known ? ps_len : '0;
      expected_words.push_back(r);
   endtask

   // Send one payload byte: idle at random, present it, hold until accepted.
   task automatic send_byte(input logic [7:0] value, input logic first);
      status_type st;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      predict_parse(value, first, st);
      status_seen[st]++;
      if (st == ST_IGNORED) ignored_items++;
      else parsed_items++;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold off the sender until every predicted word has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   function automatic logic [7:0] fill_byte(input fill_mode_type mode);
      case (mode)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         default:   return 8'($urandom);
      endcase
   endfunction

   function automatic int min_groups(input int unsigned v);
      if (v < 128) return 1;
      if (v < 16384) return 2;
      if (v < 2097152) return 3;
      return 4;
   endfunction

   // Encode a length as 7-bit groups, most significant first.
   task automatic push_length(input int unsigned value, input int nbytes, input bit all_cont);
      for (int i = nbytes - 1; i >= 0; i--)
         frame.push_back({((i != 0) || all_cont), 7'(value >> (7 * i))});
   endtask

   task automatic build_frame(input box_spec_type s);
      int n;
      frame.delete();
      repeat (4) frame.push_back(fill_byte(s.fill));
      if (s.has_es) begin
         frame.push_back(TAG_ES);
         push_length(s.es_len, s.es_nbytes, s.es_long);
         repeat (3) frame.push_back(fill_byte(s.fill));   // stream id, priority
      end else begin
         frame.push_back(s.other_tag);
         repeat (2) frame.push_back(fill_byte(s.fill));
      end
      frame.push_back(s.dec_tag);
      push_length(s.dec_len, s.dec_nbytes, s.dec_long);
      repeat (13) frame.push_back(fill_byte(s.fill));      // obj, stype, buffer, rates
      frame.push_back(s.dsi_tag);
      push_length(s.cfg_len, s.cfg_nbytes, s.cfg_long);
      n = (s.cfg_len > MAX_DSI_SENT) ? MAX_DSI_SENT : int'(s.cfg_len);
      repeat (n) frame.push_back(fill_byte(s.fill));
   endtask

   // Send the first cut bytes of the frame, the first one flagged as box start.
   task automatic send_frame(input int cut);
      for (int i = 0; i < cut && i < frame.size(); i++) begin
         if ($urandom_range(299) == 0) drain_results();
         send_byte(frame[i], i == 0);
      end
      boxes_sent++;
   endtask

   function automatic box_spec_type valid_spec(input bit with_es, input fill_mode_type mode);
      box_spec_type s;
      s.has_es     = with_es;
      s.other_tag  = 8'h00;
      s.es_len     = 20;
      s.es_nbytes  = 1;
      s.es_long    = 1'b0;
      s.dec_tag    = TAG_DEC;
      s.dec_len    = 15;
      s.dec_nbytes = 1;
      s.dec_long   = 1'b0;
      s.dsi_tag    = TAG_DSI;
      s.cfg_len    = 2;
      s.cfg_nbytes = 1;
      s.cfg_long   = 1'b0;
      s.fill       = mode;
      return s;
   endfunction

   // Mostly legal lengths; now and then a short one or a cut-off four-byte one.
   function automatic void pick_length(input int unsigned floor_ok, input int unsigned ceil_ok,
                                       output int unsigned value, output int nbytes,
                                       output bit all_cont);
      int r;
      r        = $urandom_range(99);
      all_cont = 1'b0;
      if (r < 8 && floor_ok > 0) begin
         value = $urandom_range(floor_ok - 1);
      end else if (r < 14) begin
         all_cont = 1'b1;
         value    = ($urandom_range(3) == 0) ? 0 : ($urandom & 32'h0FFF_FFFF);
      end else begin
         value = $urandom_range(ceil_ok, floor_ok);
      end
      nbytes = all_cont ? 4 : $urandom_range(4, min_groups(value));
   endfunction

   function automatic box_spec_type random_spec();
      box_spec_type s;
      int           r;
      r = $urandom_range(9);
      if (r == 0) s.fill = FILL_ZERO;
      else if (r == 1) s.fill = FILL_ONES;
      else s.fill = FILL_RANDOM;
      s.has_es    = ($urandom_range(9) < 7);
      s.other_tag = 8'($urandom);
      if (s.other_tag == TAG_ES) s.other_tag = TAG_DEC;
      pick_length(32'(ES_MIN_LEN), 300, s.es_len, s.es_nbytes, s.es_long);
      s.dec_tag = ($urandom_range(99) < 93) ? TAG_DEC : 8'($urandom);
      pick_length(32'(DEC_MIN_LEN), 400, s.dec_len, s.dec_nbytes, s.dec_long);
      s.dsi_tag = ($urandom_range(99) < 93) ? TAG_DSI : 8'($urandom);
      pick_length(0, ($urandom_range(4) == 0) ? 40 : 8, s.cfg_len, s.cfg_nbytes, s.cfg_long);
      return s;
   endfunction

   task automatic test_ignored_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
   endtask

   task automatic test_box_without_es_descriptor();
      box_spec_type s;
      s           = valid_spec(1'b0, FILL_ONES);
      s.other_tag = 8'hFF;
      s.cfg_len   = 0;
      build_frame(s);
      send_frame(frame.size());
      send_byte(8'h5A, 1'b0);   // after done: dropped
   endtask

   task automatic test_box_with_es_descriptor();
      box_spec_type s;
      s            = valid_spec(1'b1, FILL_ZERO);
      s.es_nbytes  = 2;
      s.dec_nbytes = 4;
      s.cfg_len    = 3;
      build_frame(s);
      send_frame(frame.size());
   endtask

   task automatic test_long_lengths();
      box_spec_type s;
      s            = valid_spec(1'b1, FILL_RANDOM);
      s.es_len     = 32'h0FFF_FFFF;
      s.es_nbytes  = 4;
      s.es_long    = 1'b1;
      s.dec_nbytes = 4;
      s.dec_long   = 1'b1;
      s.cfg_len    = 0;
      s.cfg_nbytes = 4;
      s.cfg_long   = 1'b1;
      build_frame(s);
      send_frame(frame.size());
      // widest specific info length: stream a couple of bytes, then restart
      s.cfg_len = 32'h0FFF_FFFF;
      build_frame(s);
      send_frame(frame.size() - MAX_DSI_SENT + 2);
   endtask

   task automatic test_error_statuses();
      box_spec_type s;
      s        = valid_spec(1'b1, FILL_RANDOM);
      s.es_len = 19;
      build_frame(s);
      send_frame(frame.size());
      s         = valid_spec(1'b0, FILL_RANDOM);
      s.dec_tag = TAG_DSI;
      build_frame(s);
      send_frame(frame.size());
      s         = valid_spec(1'b1, FILL_RANDOM);
      s.dec_len = 14;
      build_frame(s);
      send_frame(frame.size());
      s         = valid_spec(1'b0, FILL_RANDOM);
      s.dsi_tag = TAG_DEC;
      build_frame(s);
      send_frame(frame.size());
   endtask

   task automatic test_restart_mid_parse();
      build_frame(valid_spec(1'b1, FILL_RANDOM));
      send_frame(2);
      send_frame(10);
      send_frame(frame.size());
   endtask

   task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int quota);
      box_spec_type s;
      int           start_count;
      int           r;
      int           n;
      send_idle_pct = tx_pct;
      recv_idle_pct = rx_pct;
      start_count   = parsed_items;
      while (parsed_items - start_count < quota) begin
         r = $urandom_range(99);
         if (r < 80) begin
            s = random_spec();
            build_frame(s);
            send_frame(frame.size());
         end else if (r < 90) begin
            // broken box: cut short, the next box start restarts the parser
            s = random_spec();
            build_frame(s);
            send_frame($urandom_range(frame.size() - 1, 1));
         end else begin
            n = $urandom_range(6, 1);
            repeat (n) send_byte(8'($urandom), $urandom_range(4) == 0);
         end
      end
      drain_results();
   endtask

   // Randomize receiver back-pressure on every cycle.
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      end
   endfunction

   // Compare every accepted result word with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $error("result word with no prediction pending");
         end else begin
            head = expected_words.pop_front();
            check_field("status", 32'(head.status), 32'(rsp_tdata[2:0]));
            check_field("config_byte", 32'(head.config_byte), 32'(rsp_tdata[10:3]));
            check_field("config_valid", 32'(head.config_valid), 32'(rsp_tuser));
            check_field("full_box_word", head.full_box_word, rsp_tdata[42:11]);
            check_field("es_id", 32'(head.es_id), 32'(rsp_tdata[58:43]));
            check_field("es_priority", 32'(head.es_priority), 32'(rsp_tdata[66:59]));
            check_field("object_type", 32'(head.object_type), 32'(rsp_tdata[74:67]));
            check_field("stream_type", 32'(head.stream_type), 32'(rsp_tdata[82:75]));
            check_field("buffer_size", 32'(head.buffer_size), 32'(rsp_tdata[106:83]));
            check_field("max_bitrate", head.max_bitrate, rsp_tdata[138:107]);
            check_field("avg_bitrate", head.avg_bitrate, rsp_tdata[170:139]);
            check_field("config_length", 32'(head.config_length),
                        32'(rsp_tdata[198:171]));
         end
      end
   end

   // Stop a hung run: count cycles in which no word moves on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("es_descriptor_parser_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_ignored_bytes();
      test_box_without_es_descriptor();
      test_box_with_es_descriptor();
      test_long_lengths();
      test_error_statuses();
      test_restart_mid_parse();
      drain_results();
      test_random_traffic(29, 74, ITEM_COUNT / 3);
      test_random_traffic(74, 29, ITEM_COUNT / 3);
      test_random_traffic(0, 0, ITEM_COUNT - 2 * (ITEM_COUNT / 3));
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d parsed and %0d dropped bytes over %0d boxes, three idle mixes.",
               parsed_items, ignored_items, boxes_sent);
      $display("Statuses busy %0d done %0d short-es %0d no-dec %0d short-dec %0d",
               status_seen[ST_BUSY], status_seen[ST_DONE], status_seen[ST_SHORT_ES],
               status_seen[ST_NO_DEC], status_seen[ST_SHORT_DEC]);
      $display("         no-dsi %0d idle %0d",
               status_seen[ST_NO_DSI], status_seen[ST_IGNORED]);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("es_descriptor_parser_unit regression: pass");
      end else begin
         $display("es_descriptor_parser_unit regression: fail");
      end
      $finish;
   end

endmodule
